// ===== src/tgr_pkg.sv =====
package tgr_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned CoordW   = 9;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned LptW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CmdSample = 2'd0,
    CmdPoll   = 2'd1,
    CmdHint   = 2'd2,
    CmdCancel = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KindTap   = 3'd0,
    KindLong  = 3'd1,
    KindLeft  = 3'd2,
    KindRight = 3'd3,
    KindUp    = 3'd4,
    KindDown  = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable   = 2'd0,
    CfgMoveThr  = 2'd1,
    CfgSwipeThr = 2'd2,
    CfgLongTime = 2'd3
  } cfg_idx_e;

  localparam logic [ThrW-1:0] MoveThrRst  = 8'd10;
  localparam logic [ThrW-1:0] SwipeThrRst = 8'd28;
  localparam logic [LptW-1:0] LongTimeRst = 16'd600;

endpackage

// ===== src/tgr_in_if.sv =====
interface tgr_in_if import tgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic              pressed;
  logic [TimeW-1:0]  now_ms;
  logic [TimeW-1:0]  event_time;
  logic [KindW-1:0]  hint_kind;

  modport source (
    output valid, cmd, pos_x, pos_y, pressed, now_ms, event_time, hint_kind,
    input  ready
  );
  modport sink (
    input  valid, cmd, pos_x, pos_y, pressed, now_ms, event_time, hint_kind,
    output ready
  );
endinterface

// ===== src/tgr_out_if.sv =====
interface tgr_out_if import tgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  gesture_kind;
  logic [CoordW-1:0] origin_x;
  logic [CoordW-1:0] origin_y;
  logic [TimeW-1:0]  gesture_time;

  modport source (
    output valid, gesture_kind, origin_x, origin_y, gesture_time,
    input  ready
  );
  modport sink (
    input  valid, gesture_kind, origin_x, origin_y, gesture_time,
    output ready
  );
endinterface

// ===== src/touch_gesture_recognizer.sv =====
// Touch gesture recogniser.
// in_i  : touch commands (sample, time poll, hint, cancel), valid/ready.
// out_o : gestures (kind, press start position, time stamp), valid/ready.
// cfg   : write-only port, cfg_we_i with cfg_idx_i selecting enable, move
//         threshold, swipe threshold or long press time; write while idle.
// An accepted item is held in an input register; when that register moves on,
// the classification is made against the press state and, if a gesture results
// and enable is set, it is loaded into the output register behind out_o.valid.
// One item per cycle is sustained: the input register moves on whenever the
// output register is empty or is being taken in the same cycle.
// A stalled receiver holds the gesture in the output register; one further
// item waits in the input register, then in_i.ready drops until out_o moves.
// Items that give no gesture still update the state and leave nothing.
// Reset empties both registers, clears the press state and loads the
// threshold defaults (enable off, 10, 28, 600 ms).
module touch_gesture_recognizer import tgr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tgr_in_if.sink              in_i,
  tgr_out_if.source           out_o
);

  // configuration
  logic            enable_q;
  logic [ThrW-1:0] move_thr_q, swipe_thr_q;
  logic [LptW-1:0] long_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      move_thr_q  <= MoveThrRst;
      swipe_thr_q <= SwipeThrRst;
      long_time_q <= LongTimeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEnable:   enable_q    <= cfg_data_i[0];
        CfgMoveThr:  move_thr_q  <= cfg_data_i[ThrW-1:0];
        CfgSwipeThr: swipe_thr_q <= cfg_data_i[ThrW-1:0];
        CfgLongTime: long_time_q <= cfg_data_i[LptW-1:0];
        default:     ;
      endcase
    end
  end

  // input register
  logic              inq_valid_q;
  logic [CmdW-1:0]   inq_cmd_q;
  logic [CoordW-1:0] inq_x_q, inq_y_q;
  logic              inq_pressed_q;
  logic [TimeW-1:0]  inq_now_q, inq_etime_q;
  logic [KindW-1:0]  inq_hint_q;

  logic out_valid_q;
  logic advance;
  logic in_fire;

  assign advance    = inq_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !inq_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_cmd_q     <= in_i.cmd;
      inq_x_q       <= in_i.pos_x;
      inq_y_q       <= in_i.pos_y;
      inq_pressed_q <= in_i.pressed;
      inq_now_q     <= in_i.now_ms;
      inq_etime_q   <= in_i.event_time;
      inq_hint_q    <= in_i.hint_kind;
    end
  end

  // press state
  logic              is_down_q, is_down_d;
  logic              has_moved_q, has_moved_d;
  logic              long_sent_q, long_sent_d;
  logic [CoordW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [TimeW-1:0]  start_time_q, start_time_d;

  // classification
  logic              neg_x, neg_y;
  logic [CoordW-1:0] ax, ay;
  logic [TimeW-1:0]  elapsed;
  logic              held_long, moved_now, over_move;
  logic              res_hit;
  kind_e             res_kind;
  logic [TimeW-1:0]  res_time;

  assign neg_x     = inq_x_q < start_x_q;
  assign neg_y     = inq_y_q < start_y_q;
  assign ax        = neg_x ? start_x_q - inq_x_q : inq_x_q - start_x_q;
  assign ay        = neg_y ? start_y_q - inq_y_q : inq_y_q - start_y_q;
  assign elapsed   = inq_now_q - start_time_q;
  assign held_long = elapsed >= {{(TimeW-LptW){1'b0}}, long_time_q};
  assign over_move = (ax > {1'b0, move_thr_q}) || (ay > {1'b0, move_thr_q});
  assign moved_now = has_moved_q || over_move;

  always_comb begin
    is_down_d    = is_down_q;
    has_moved_d  = has_moved_q;
    long_sent_d  = long_sent_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    start_time_d = start_time_q;
    res_hit      = 1'b0;
    res_kind     = KindTap;
    res_time     = inq_now_q;
    case (cmd_e'(inq_cmd_q))
      CmdSample: begin
        res_time = inq_etime_q;
        if (inq_pressed_q && !is_down_q) begin
          is_down_d    = 1'b1;
          start_x_d    = inq_x_q;
          start_y_d    = inq_y_q;
          start_time_d = inq_now_q;
          has_moved_d  = 1'b0;
          long_sent_d  = 1'b0;
        end else if (is_down_q) begin
          has_moved_d = moved_now;
          if (!inq_pressed_q) begin
            is_down_d = 1'b0;
            if (!long_sent_q) begin
              if (ax > {1'b0, swipe_thr_q} && ax > ay) begin
                res_hit  = 1'b1;
                res_kind = neg_x ? KindLeft : KindRight;
              end else if (ay > {1'b0, swipe_thr_q} && ay > ax) begin
                res_hit  = 1'b1;
                res_kind = neg_y ? KindUp : KindDown;
              end else if (!moved_now) begin
                res_hit  = 1'b1;
                res_kind = held_long ? KindLong : KindTap;
              end
            end
          end
        end
      end
      CmdPoll: begin
        if (is_down_q && !has_moved_q && !long_sent_q && held_long) begin
          long_sent_d = 1'b1;
          res_hit     = 1'b1;
          res_kind    = KindLong;
        end
      end
      CmdHint: begin
        // codes above a down swipe mean nothing and are dropped
        if (inq_hint_q <= KindDown && !long_sent_q) begin
          long_sent_d = 1'b1;
          res_hit     = 1'b1;
          res_kind    = kind_e'(inq_hint_q);
        end
      end
      default: begin
        is_down_d   = 1'b0;
        has_moved_d = 1'b0;
        long_sent_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q    <= 1'b0;
      has_moved_q  <= 1'b0;
      long_sent_q  <= 1'b0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_time_q <= '0;
    end else if (advance) begin
      is_down_q    <= is_down_d;
      has_moved_q  <= has_moved_d;
      long_sent_q  <= long_sent_d;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      start_time_q <= start_time_d;
    end
  end

  // output register
  kind_e             out_kind_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic [TimeW-1:0]  out_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_hit && enable_q;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= res_kind;
      out_x_q    <= start_x_q;
      out_y_q    <= start_y_q;
      out_time_q <= res_time;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.gesture_kind = out_kind_q;
  assign out_o.origin_x     = out_x_q;
  assign out_o.origin_y     = out_y_q;
  assign out_o.gesture_time = out_time_q;

endmodule

// ===== src/tgr_checker.sv =====
module tgr_checker import tgr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [KindW-1:0] out_kind_i
);

  // a waiting gesture is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("gesture dropped while stalled");

  // with nothing waiting at the output, an item is always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a fresh gesture is preceded by an accepted item that passed the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("gesture without a preceding item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_kind_i <= KindDown)
    else $error("gesture kind out of range");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.gesture_kind)
);

// ===== bench/tb_top.sv =====
module tb_top;
  import tgr_pkg::*;

  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic              pressed;
    logic [TimeW-1:0]  now_ms;
    logic [TimeW-1:0]  event_time;
    logic [KindW-1:0]  hint_kind;
  } touch_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [TimeW-1:0]  stamp;
  } gesture_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tgr_in_if  in_bus ();
  tgr_out_if out_bus ();

  touch_gesture_recognizer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #1 clk = ~clk;

  // shadow registers
  logic              en_cfg;
  logic [ThrW-1:0]   move_thr;
  logic [ThrW-1:0]   swipe_thr;
  logic [LptW-1:0]   long_time;

  // shadow press state
  logic              is_down   = 1'b0;
  logic [CoordW-1:0] press_x   = '0;
  logic [CoordW-1:0] press_y   = '0;
  logic [TimeW-1:0]  press_t   = '0;
  logic              moved     = 1'b0;
  logic              long_done = 1'b0;

  touch_item_t touch_q[$];
  gesture_t    gesture_q[$];
  touch_item_t cur_item;

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int          in_gap     = 0;
  int          out_hold   = 0;
  bit          idle_on    = 1'b1;
  bit          stall_req  = 1'b0;
  bit          hold_long  = 1'b0;

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    n_errors++;
  endtask

  task automatic predict_gesture(input touch_item_t it);
    logic              neg_x;
    logic              neg_y;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [TimeW-1:0]  held;
    logic              fire;
    kind_e             kind;
    logic [TimeW-1:0]  stamp;
    fire  = 1'b0;
    kind  = KindTap;
    stamp = it.now_ms;
    held  = it.now_ms - press_t;
    case (it.cmd)
      CmdSample: begin
        if (it.pressed && !is_down) begin
          is_down   = 1'b1;
          press_x   = it.pos_x;
          press_y   = it.pos_y;
          press_t   = it.now_ms;
          moved     = 1'b0;
          long_done = 1'b0;
        end else if (is_down) begin
          neg_x = it.pos_x < press_x;
          neg_y = it.pos_y < press_y;
          dx = neg_x ? press_x - it.pos_x : it.pos_x - press_x;
          dy = neg_y ? press_y - it.pos_y : it.pos_y - press_y;
          if (dx > move_thr || dy > move_thr) moved = 1'b1;
          if (!it.pressed) begin
            is_down = 1'b0;
            stamp = it.event_time;
            if (!long_done) begin
              if (dx > swipe_thr && dx > dy) begin
                fire = 1'b1;
                kind = neg_x ? KindLeft : KindRight;
              end else if (dy > swipe_thr && dy > dx) begin
                fire = 1'b1;
                kind = neg_y ? KindUp : KindDown;
              end else if (!moved) begin
                fire = 1'b1;
                kind = (held < long_time) ? KindTap : KindLong;
              end
            end
          end
        end
      end
      CmdPoll: begin
        if (is_down && !moved && !long_done && held >= long_time) begin
          long_done = 1'b1;
          fire = 1'b1;
          kind = KindLong;
        end
      end
      CmdHint: begin
        if (it.hint_kind <= KindDown && !long_done) begin
          long_done = 1'b1;
          fire = 1'b1;
          kind = kind_e'(it.hint_kind);
        end
      end
      default: begin
        is_down   = 1'b0;
        moved     = 1'b0;
        long_done = 1'b0;
      end
    endcase
    if (fire && en_cfg) gesture_q.push_back('{kind, press_x, press_y, stamp});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_gesture(cur_item);
        n_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (touch_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(0, 16);
            in_bus.valid <= 1'b0;
          end else begin
            cur_item = touch_q.pop_front();
            in_bus.valid      <= 1'b1;
            in_bus.cmd        <= cur_item.cmd;
            in_bus.pos_x      <= cur_item.pos_x;
            in_bus.pos_y      <= cur_item.pos_y;
            in_bus.pressed    <= cur_item.pressed;
            in_bus.now_ms     <= cur_item.now_ms;
            in_bus.event_time <= cur_item.event_time;
            in_bus.hint_kind  <= cur_item.hint_kind;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end else begin
      in_bus.valid      <= 1'b0;
      in_bus.cmd        <= CmdSample;
      in_bus.pos_x      <= '0;
      in_bus.pos_y      <= '0;
      in_bus.pressed    <= 1'b0;
      in_bus.now_ms     <= '0;
      in_bus.event_time <= '0;
      in_bus.hint_kind  <= '0;
    end
  end

  // long receiver stall, counted in cycles
  initial begin
    wait (stall_req);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    gesture_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (gesture_q.size() == 0) begin
          flag_mismatch("unexpected gesture kind", 32'(out_bus.gesture_kind), 0);
        end else begin
          want = gesture_q.pop_front();
          if (out_bus.gesture_kind !== want.kind)
            flag_mismatch("gesture_kind", 32'(out_bus.gesture_kind), 32'(want.kind));
          if (out_bus.origin_x !== want.x)
            flag_mismatch("origin_x", 32'(out_bus.origin_x), 32'(want.x));
          if (out_bus.origin_y !== want.y)
            flag_mismatch("origin_y", 32'(out_bus.origin_y), 32'(want.y));
          if (out_bus.gesture_time !== want.stamp)
            flag_mismatch("gesture_time", out_bus.gesture_time, want.stamp);
        end
      end
      if (hold_long) begin
        out_bus.ready <= 1'b0;
      end else if (out_hold > 0) begin
        out_hold--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(0, 16);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  task automatic push_item(cmd_e cmd, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                           logic pressed, logic [TimeW-1:0] now_ms,
                           logic [TimeW-1:0] etime, logic [KindW-1:0] hint);
    touch_q.push_back('{cmd, x, y, pressed, now_ms, etime, hint});
    n_queued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgEnable:   en_cfg    = val[0];
      CfgMoveThr:  move_thr  = val[ThrW-1:0];
      CfgSwipeThr: swipe_thr = val[ThrW-1:0];
      default:     long_time = val[LptW-1:0];
    endcase
  endtask

  task automatic set_regs(logic en, int unsigned mv, int unsigned sw, int unsigned lpt);
    write_reg(CfgEnable, CfgDataW'(en));
    write_reg(CfgMoveThr, CfgDataW'(mv));
    write_reg(CfgSwipeThr, CfgDataW'(sw));
    write_reg(CfgLongTime, CfgDataW'(lpt));
  endtask

  // all items taken, all gestures seen, then a wait so that no-result items drain
  task automatic wait_idle();
    while (n_accepted != n_queued || gesture_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [CoordW-1:0] near_coord(logic [CoordW-1:0] base, int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return v[CoordW-1:0];
  endfunction

  // hold durations round the long press boundary, below half of it, or random
  function automatic logic [TimeW-1:0] pick_hold();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        v = int'(long_time) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        return v;
      end
      1: return $urandom_range(0, long_time / 2);
      2: return long_time + $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_touch_seq();
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic [TimeW-1:0]  t0;
    int                span;
    int                n_mid;
    sx = CoordW'($urandom_range(0, 511));
    sy = CoordW'($urandom_range(0, 511));
    t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 700) : $urandom;
    push_item(CmdSample, sx, sy, 1'b1, t0, $urandom, KindW'($urandom_range(0, 7)));
    n_mid = $urandom_range(0, 3);
    repeat (n_mid) begin
      case ($urandom_range(0, 5))
        0, 1: push_item(CmdSample, near_coord(sx, move_thr + 2), near_coord(sy, move_thr + 2),
                        1'b1, t0 + pick_hold(), $urandom, KindW'($urandom_range(0, 7)));
        2, 3: push_item(CmdPoll, CoordW'($urandom_range(0, 511)),
                        CoordW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                        t0 + pick_hold(), $urandom, KindW'($urandom_range(0, 7)));
        4: push_item(CmdHint, CoordW'($urandom_range(0, 511)),
                     CoordW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                     t0 + pick_hold(), $urandom, KindW'($urandom_range(0, 7)));
        default: push_item(CmdCancel, CoordW'($urandom_range(0, 511)),
                           CoordW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                           $urandom, $urandom, KindW'($urandom_range(0, 7)));
      endcase
    end
    case ($urandom_range(0, 2))
      0: span = int'(move_thr);
      1: span = int'(swipe_thr) + 16;
      default: span = 511;
    endcase
    push_item(CmdSample, near_coord(sx, span), near_coord(sy, span), 1'b0,
              t0 + pick_hold(), $urandom, KindW'($urandom_range(0, 7)));
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned target;
    target = n_queued + n_items;
    while (n_queued < target) begin
      if ($urandom_range(0, 4) != 0) begin
        queue_touch_seq();
      end else begin
        push_item(cmd_e'($urandom_range(0, 3)), CoordW'($urandom_range(0, 511)),
                  CoordW'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                  $urandom, $urandom, KindW'($urandom_range(0, 7)));
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgEnable;
    cfg_data  = '0;
    en_cfg    = 1'b0;
    move_thr  = MoveThrRst;
    swipe_thr = SwipeThrRst;
    long_time = LongTimeRst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_regs(1'b1, 10, 28, 600);
    // hint with no press uses the reset start position, then is blocked
    push_item(CmdHint, 9'd5, 9'd5, 1'b0, 32'hFFFF_FFFF, 32'h0, KindDown);
    push_item(CmdHint, 9'd5, 9'd5, 1'b0, 32'h1, 32'h0, KindTap);
    push_item(CmdHint, 9'd0, 9'd0, 1'b1, 32'h2, 32'h0, 3'd6);
    // swipes in all four directions
    push_item(CmdSample, 9'd0, 9'd0, 1'b1, 32'd100, 32'h0, 3'd7);
    push_item(CmdSample, 9'd100, 9'd5, 1'b0, 32'd150, 32'hFFFF_FFFF, 3'd0);
    push_item(CmdSample, 9'd511, 9'd511, 1'b1, 32'd200, 32'h0, 3'd0);
    push_item(CmdSample, 9'd400, 9'd505, 1'b0, 32'd250, 32'h1234_5678, 3'd0);
    push_item(CmdSample, 9'd200, 9'd200, 1'b1, 32'd300, 32'h0, 3'd0);
    push_item(CmdSample, 9'd210, 9'd150, 1'b0, 32'd350, 32'hA5A5_A5A5, 3'd0);
    push_item(CmdSample, 9'd200, 9'd200, 1'b1, 32'd400, 32'h0, 3'd0);
    push_item(CmdSample, 9'd205, 9'd260, 1'b0, 32'd450, 32'h5A5A_5A5A, 3'd0);
    // tap, and long press on release exactly at the hold time
    push_item(CmdSample, 9'd300, 9'd300, 1'b1, 32'd1000, 32'h0, 3'd0);
    push_item(CmdSample, 9'd305, 9'd305, 1'b0, 32'd1100, 32'd1111, 3'd0);
    push_item(CmdSample, 9'd300, 9'd300, 1'b1, 32'd2000, 32'h0, 3'd0);
    push_item(CmdSample, 9'd300, 9'd300, 1'b0, 32'd2600, 32'd2222, 3'd0);
    // polls across the time wrap; release after a long press gives nothing
    push_item(CmdSample, 9'd60, 9'd70, 1'b1, 32'hFFFF_FF00, 32'h0, 3'd0);
    push_item(CmdPoll, 9'd0, 9'd0, 1'b1, 32'h0000_0100, 32'h0, 3'd0);
    push_item(CmdPoll, 9'd0, 9'd0, 1'b1, 32'h0000_0200, 32'h0, 3'd0);
    push_item(CmdSample, 9'd60, 9'd70, 1'b0, 32'h0000_0300, 32'h0, 3'd0);
    // moved without a swipe, then an equal-axis release
    push_item(CmdSample, 9'd100, 9'd100, 1'b1, 32'd5000, 32'h0, 3'd0);
    push_item(CmdSample, 9'd115, 9'd100, 1'b1, 32'd5010, 32'h0, 3'd0);
    push_item(CmdSample, 9'd100, 9'd100, 1'b0, 32'd5020, 32'h0, 3'd0);
    push_item(CmdSample, 9'd50, 9'd50, 1'b1, 32'd6000, 32'h0, 3'd0);
    push_item(CmdSample, 9'd90, 9'd90, 1'b0, 32'd6010, 32'h0, 3'd0);
    // cancel drops the press; the following release is ignored
    push_item(CmdSample, 9'd20, 9'd20, 1'b1, 32'd7000, 32'h0, 3'd0);
    push_item(CmdCancel, 9'd0, 9'd0, 1'b0, 32'd7001, 32'h0, 3'd0);
    push_item(CmdSample, 9'd20, 9'd20, 1'b0, 32'd7002, 32'h0, 3'd0);
    wait_idle();

    set_regs(1'b1, $urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 2000));
    run_random(100);
    set_regs(1'b1, 0, 0, 0);
    run_random(80);
    set_regs(1'b1, 255, 255, 65535);
    run_random(80);
    set_regs(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535));
    run_random(60);
    // receiver holds off long enough for the block to back up
    set_regs(1'b1, 10, 28, 600);
    stall_req = 1'b1;
    run_random(100);
    idle_on = 1'b0;
    set_regs(1'b1, $urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 2000));
    run_random(80);

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
